/* src/lateral_state_feedback_controller_assert.svh */
// Assertion macros used by the controller top level.
`ifndef LATERAL_STATE_FEEDBACK_CONTROLLER_ASSERT_SVH
`define LATERAL_STATE_FEEDBACK_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define LSFC_ASSERT_SAME(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define LSFC_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* src/lsfc_pkg.sv */
package lsfc_pkg;

  localparam int SCENARIOS_DEF = 4;
  localparam int SET_SIZE = 83;
  localparam int OFS_T = 0;
  localparam int OFS_K = 36;
  localparam int OFS_PHI = 41;
  localparam int OFS_GAMMA = 77;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    logic               is_step;
    logic [1:0]         scenario;
    logic [6:0]         coef_index;
    logic signed [31:0] value;
    logic               first_step;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_OUT
  } back_state_t;

  // Saturate a 64-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic is_sat(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

/* src/lsfc_front.sv */
module lsfc_front #(
  parameter int SCENARIOS = lsfc_pkg::SCENARIOS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [1:0]           scenario,
  input  logic [6:0]           coef_index,
  input  logic signed [31:0]   coef_value,
  input  logic signed [31:0]   measurement,
  input  logic                 first_step,
  output logic                 q_valid,
  input  logic                 q_ready,
  output lsfc_pkg::work_t      q_item
);
  import lsfc_pkg::*;

  // Two-entry queue; items that do nothing are dropped here.
  work_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  logic       pop;
  work_t      item;

  always_comb begin
    item.is_step    = (command == CMD_STEP);
    item.scenario   = scenario;
    item.coef_index = coef_index;
    item.value      = (command == CMD_STEP) ? measurement : coef_value;
    item.first_step = first_step;
    keep = ({30'd0, scenario} < SCENARIOS) &&
           ((command == CMD_STEP) || (coef_index < 7'(SET_SIZE)));
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* src/lsfc_back.sv */
module lsfc_back #(
  parameter int SCENARIOS = lsfc_pkg::SCENARIOS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] curvature_gain,
  input  logic               q_valid,
  output logic               q_ready,
  input  lsfc_pkg::work_t    q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] steering_angle,
  output logic               saturated
);
  import lsfc_pkg::*;

  localparam int DEPTH = SCENARIOS * SET_SIZE;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Micro-step encoding: 0 curvature, 1..30 T rows 1..5, 31..35 K,
  // 36..56 phi rows 0,1,3 with Gamma after each row.
  localparam int NSTEP = 57;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [AW-1:0]      rd_addr;

  back_state_t state, state_next;
  logic [5:0]  step;
  logic [1:0]  scen;
  logic signed [31:0] z [6];
  logic signed [31:0] zt [5];
  logic signed [31:0] u;
  logic signed [31:0] ns [3];
  logic signed [31:0] hist0, hist1;
  logic signed [31:0] s1, s2, s4;
  logic signed [63:0] acc;
  logic        flag;
  logic signed [31:0] opa;
  logic signed [63:0] prod;
  logic signed [63:0] term;

  // Step decode into coefficient offset and data operand.
  logic [6:0]  coff;
  logic [2:0]  dsel;      // 0..5 z, 6 u, 7 zt
  logic        last;      // final term of a sum
  logic [3:0]  tgt;       // zt index, 5 = u, 6..8 ns
  logic [2:0]  ti;

  always_comb begin
    coff = '0; dsel = '0; last = 1'b0; tgt = '0; ti = '0;
    if (step == 6'd0) begin
      dsel = 3'd2; last = 1'b1;
    end else if (step <= 6'd30) begin
      priority if (step >= 6'd25) begin
        ti = 3'd4; dsel = 3'(step - 6'd25);
      end else if (step >= 6'd19) begin
        ti = 3'd3; dsel = 3'(step - 6'd19);
      end else if (step >= 6'd13) begin
        ti = 3'd2; dsel = 3'(step - 6'd13);
      end else if (step >= 6'd7) begin
        ti = 3'd1; dsel = 3'(step - 6'd7);
      end else begin
        ti = 3'd0; dsel = 3'(step - 6'd1);
      end
      coff = 7'(OFS_T) + 7'(6 * (ti + 3'd1)) + 7'(dsel);
      last = (dsel == 3'd5); tgt = 4'(ti);
    end else if (step <= 6'd35) begin
      ti = 3'(step - 6'd31);
      coff = 7'(OFS_K) + 7'(ti);
      dsel = 3'd7; last = (ti == 3'd4); tgt = 4'd5;
    end else begin
      priority if (step >= 6'd50) begin
        ti = 3'd2; dsel = 3'(step - 6'd50);
      end else if (step >= 6'd43) begin
        ti = 3'd1; dsel = 3'(step - 6'd43);
      end else begin
        ti = 3'd0; dsel = 3'(step - 6'd36);
      end
      if (dsel == 3'd6) begin
        coff = 7'(OFS_GAMMA) + ((ti == 3'd2) ? 7'd3 : 7'(ti));
        last = 1'b1;
      end else begin
        coff = 7'(OFS_PHI) + 7'(6 * ((ti == 3'd2) ? 3'd3 : ti)) + 7'(dsel);
      end
      tgt = 4'd6 + 4'(ti);
    end
    rd_addr = AW'(32'(scen) * SET_SIZE + 32'(coff));
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && !q_item.is_step)
      mem[AW'(32'(q_item.scenario) * SET_SIZE + 32'(q_item.coef_index))] <= q_item.value;
    rd_data <= mem[rd_addr];
  end

  // Operand of the current step, registered next to the memory read.
  logic [5:0] rstep;
  always_ff @(posedge clk) begin
    rstep <= step;
    unique case (dsel)
      3'd0: opa <= z[0];
      3'd1: opa <= z[1];
      3'd2: opa <= z[2];
      3'd3: opa <= z[3];
      3'd4: opa <= z[4];
      3'd5: opa <= z[5];
      3'd6: opa <= u;
      default: opa <= zt[ti];
    endcase
  end

  logic rvalid, pvalid;
  logic rlast, plast;
  logic [3:0] rtgt, ptgt;
  logic pcurv, rcurv;

  always_ff @(posedge clk) begin
    prod <= opa * ((rstep == 6'd0) ? curvature_gain : rd_data);
    plast <= rlast; ptgt <= rtgt; pcurv <= rcurv;
  end

  assign term = pcurv ? (prod >>> 27) : (prod >>> 28);

  logic signed [63:0] sum;
  assign sum = acc + term;

  assign q_ready = (state == ST_IDLE);
  assign steering_angle = u;
  assign saturated = flag;
  assign out_valid = (state == ST_OUT);

  // Sums read z, ready at the start, except the T rows (z[4], the curvature term),
  // u (the zt sums) and the Gamma terms (u); a stall on those keeps it exact.
  logic hazard;
  always_comb begin
    hazard = 1'b0;
    if (step >= 6'd31 && step <= 6'd35 && (rvalid || pvalid) &&
        (rtgt < 4'd5 || ptgt < 4'd5)) hazard = 1'b1;
    if (step >= 6'd36 && dsel == 3'd6 && (rvalid || pvalid) &&
        (rtgt == 4'd5 || ptgt == 4'd5)) hazard = 1'b1;
    if (step == 6'd1 && (rvalid || pvalid)) hazard = 1'b1;
  end

  logic issue;
  assign issue = (state == ST_RUN) && !hazard;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid && q_item.is_step) state_next = ST_RUN;
      ST_RUN:  if (step == 6'(NSTEP - 1) && issue) state_next = ST_WAIT;
      ST_WAIT: if (!rvalid && !pvalid) state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      s1 <= '0; s2 <= '0; s4 <= '0; hist0 <= '0; hist1 <= '0;
      rvalid <= 1'b0; pvalid <= 1'b0; step <= '0;
    end else begin
      state <= state_next;
      rvalid <= issue;
      pvalid <= rvalid;
      if (state == ST_IDLE && q_valid && q_item.is_step) begin
        step <= '0; scen <= q_item.scenario; acc <= '0; flag <= 1'b0;
        z[0] <= s1; z[1] <= s2; z[2] <= q_item.value; z[3] <= s4;
        z[5] <= q_item.first_step ? 32'sd0 : hist1;
        if (q_item.first_step) hist0 <= '0;
      end
      if (issue) begin
        rlast <= last; rtgt <= tgt; rcurv <= (step == 6'd0);
        if (step != 6'(NSTEP - 1)) step <= step + 6'd1;
      end
      if (pvalid) begin
        if (plast) begin
          acc <= '0;
          if (is_sat(sum)) flag <= 1'b1;
          if (pcurv) z[4] <= sat32(sum);
          else if (ptgt < 4'd5) zt[3'(ptgt)] <= sat32(sum);
          else if (ptgt == 4'd5) u <= sat32(sum);
          else ns[2'(ptgt - 4'd6)] <= sat32(sum);
        end else acc <= sum;
      end
      if (state == ST_WAIT && !rvalid && !pvalid) begin
        s1 <= ns[0]; s2 <= ns[1]; s4 <= ns[2];
        hist1 <= hist0; hist0 <= u;
      end
      if (state == ST_IDLE && q_valid && q_item.is_step && q_item.first_step)
        hist1 <= '0;
    end
  end
endmodule

/* src/lateral_state_feedback_controller.sv */
// Channel  Direction  Signals
// cfg      in         cfg_valid, cfg_ready, cfg_data
// in       in         in_valid, in_ready, command..first_step
// out      out        out_valid, out_ready, steering_angle, saturated
// A step is accepted, then 57 multiply-accumulates are issued through one shared MAC
// (stalling where a sum waits for an earlier one), the pipeline drains and the result
// is presented. Loads are written to memory when the back end takes them;
// a two-entry queue sits between the parts.
// Reset is synchronous; the coefficient memory is not cleared.
// The result register holds until out_ready; no item enters the back end meanwhile.
module lateral_state_feedback_controller #(
  parameter int SCENARIOS = lsfc_pkg::SCENARIOS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [1:0]         scenario,
  input  logic [6:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] measurement,
  input  logic               first_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] steering_angle,
  output logic               saturated
);
  import lsfc_pkg::*;
  `include "lateral_state_feedback_controller_assert.svh"

  logic signed [31:0] curvature_gain;
  logic  q_valid, q_ready;
  work_t q_item;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) curvature_gain <= '0;
    else if (cfg_valid) curvature_gain <= cfg_data;
  end

  lsfc_front #(.SCENARIOS(SCENARIOS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .scenario, .coef_index,
    .coef_value, .measurement, .first_step, .q_valid, .q_ready, .q_item
  );

  lsfc_back #(.SCENARIOS(SCENARIOS)) u_back (
    .clk, .rst, .curvature_gain, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .steering_angle, .saturated
  );

  `LSFC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(steering_angle), "result dropped")
  `LSFC_ASSERT_SAME(a_no_pop_busy, clk, rst, out_valid, !q_ready, "queue popped while result waits")
endmodule

/* bench/tb_lateral_state_feedback_controller.sv */
module tb_lateral_state_feedback_controller;
  import lsfc_pkg::*;

  localparam int NUM_SETS = 4;
  localparam int SETTLE_CYCLES = 120;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic signed [31:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = 1'b0;
  logic [1:0]         scenario = '0;
  logic [6:0]         coef_index = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] measurement = '0;
  logic               first_step = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] steering_angle;
  logic               saturated;

  lateral_state_feedback_controller dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .scenario(scenario), .coef_index(coef_index), .coef_value(coef_value),
    .measurement(measurement), .first_step(first_step),
    .out_valid(out_valid), .out_ready(out_ready),
    .steering_angle(steering_angle), .saturated(saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    logic signed [31:0] angle;
    logic               clipped;
  } steer_t;

  // Controller state kept alongside the block.
  longint gain_q;
  longint coef_mem [NUM_SETS][SET_SIZE];
  longint lat_one, lat_two, lat_four;
  longint prev_angle, older_angle;
  steer_t angle_queue[$];

  int  mismatches = 0;
  bit  calm = 1'b0;

  function automatic longint clip32(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Q16.16 times Q4.28, floor to Q16.16.
  function automatic longint qmul(longint d, longint c);
    return (d * c) >>> 28;
  endfunction

  function automatic void apply_item(logic cmd, logic [1:0] scen, logic [6:0] idx,
                                     logic signed [31:0] cval, logic signed [31:0] meas,
                                     logic first);
    longint z[6];
    longint zt[6];
    longint acc, u;
    longint ns[3];
    bit     flag;
    int     r;
    steer_t res;
    flag = 1'b0;
    if (scen >= NUM_SETS) return;
    if (cmd == CMD_LOAD) begin
      if (idx < SET_SIZE) coef_mem[scen][idx] = cval;
      return;
    end
    if (first) begin
      prev_angle = 0;
      older_angle = 0;
    end
    z[0] = lat_one;
    z[1] = lat_two;
    z[2] = meas;
    z[3] = lat_four;
    z[4] = clip32((longint'(meas) * gain_q) >>> 27, flag);
    z[5] = older_angle;
    for (int i = 1; i < 6; i++) begin
      acc = 0;
      for (int j = 0; j < 6; j++) acc += qmul(z[j], coef_mem[scen][OFS_T + i * 6 + j]);
      zt[i] = clip32(acc, flag);
    end
    acc = 0;
    for (int i = 0; i < 5; i++) acc += qmul(zt[i + 1], coef_mem[scen][OFS_K + i]);
    u = clip32(acc, flag);
    for (int i = 0; i < 3; i++) begin
      r = (i == 2) ? 3 : i;
      acc = qmul(u, coef_mem[scen][OFS_GAMMA + r]);
      for (int j = 0; j < 6; j++) acc += qmul(z[j], coef_mem[scen][OFS_PHI + r * 6 + j]);
      ns[i] = clip32(acc, flag);
    end
    lat_one = ns[0];
    lat_two = ns[1];
    lat_four = ns[2];
    older_angle = prev_angle;
    prev_angle = u;
    res.angle = u[31:0];
    res.clipped = flag;
    angle_queue.push_back(res);
  endfunction

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic send_item(logic cmd, logic [1:0] scen, logic [6:0] idx,
                           logic signed [31:0] cval, logic signed [31:0] meas, logic first);
    idle_gap();
    command = cmd;
    scenario = scen;
    coef_index = idx;
    coef_value = cval;
    measurement = meas;
    first_step = first;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_item(cmd, scen, idx, cval, meas, first);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (angle_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_gain(logic signed [31:0] v);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    gain_q = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly coefficients below one in magnitude so the states stay in range.
  function automatic logic signed [31:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_meas();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  task automatic load_set(logic [1:0] scen);
    for (int k = 0; k < SET_SIZE; k++)
      send_item(CMD_LOAD, scen, 7'(k), pick_coef(), 32'sd0, 1'b0);
  endtask

  task automatic test_load_all_sets();
    for (int s = 0; s < NUM_SETS; s++) load_set(2'(s));
    drain();
  endtask

  task automatic test_directed_steps();
    send_item(CMD_STEP, 2'd0, 7'd0, 32'sd0, 32'sh7fffffff, 1'b1);
    send_item(CMD_STEP, 2'd0, 7'd0, 32'sd0, 32'sh80000000, 1'b0);
    send_item(CMD_STEP, 2'd1, 7'h7f, 32'sh7fffffff, 32'sd0, 1'b0);
    send_item(CMD_STEP, 2'd3, 7'd0, 32'sd0, 32'sh0001_0000, 1'b0);
    send_item(CMD_STEP, 2'd2, 7'd0, 32'sd0, -32'sh0001_0000, 1'b1);
    // Loads past the last coefficient must leave the set untouched; the next two hit index 36 and the last index.
    send_item(CMD_LOAD, 2'd2, 7'd83, 32'sh7fffffff, 32'sd0, 1'b0);
    send_item(CMD_LOAD, 2'd1, 7'h7f, 32'sh80000000, 32'sd0, 1'b0);
    send_item(CMD_LOAD, 2'd0, 7'd36, 32'sh80000000, 32'sd0, 1'b0);
    send_item(CMD_LOAD, 2'd3, 7'd82, 32'sh7fffffff, 32'sd0, 1'b0);
    for (int i = 0; i < 8; i++)
      send_item(CMD_STEP, 2'(i % NUM_SETS), 7'd0, 32'sd0, pick_meas(), i == 4);
    drain();
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_item(CMD_LOAD, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                  pick_coef(), $urandom, 1'($urandom_range(0, 1)));
      else
        send_item(CMD_STEP, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                  $urandom, pick_meas(), $urandom_range(0, 9) == 0);
    end
    drain();
  endtask

  task automatic test_gain_settings();
    write_gain(32'sh7fffffff);
    test_random_traffic(250);
    write_gain(32'sh80000000);
    test_random_traffic(250);
    write_gain($urandom);
    test_random_traffic(250);
    write_gain($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    test_random_traffic(300);
  endtask

  task automatic test_no_idling();
    calm = 1'b1;
    write_gain(32'sh0100_0000);
    test_random_traffic(150);
  endtask

  // Result side stalls in bursts until the final phase.
  initial begin
    forever begin
      @(negedge clk);
      if (calm) out_ready = 1'b1;
      else if ($urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    steer_t want;
    if (!rst && out_valid && out_ready) begin
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result angle=%0d", steering_angle);
      end else begin
        want = angle_queue.pop_front();
        if (steering_angle !== want.angle || saturated !== want.clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle exp %0d got %0d, saturated exp %0b got %0b",
                     want.angle, steering_angle, want.clipped, saturated);
        end
      end
    end
  end

  initial begin
    gain_q = 0;
    lat_one = 0;
    lat_two = 0;
    lat_four = 0;
    prev_angle = 0;
    older_angle = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    write_gain(32'sd0);
    test_load_all_sets();
    test_directed_steps();
    test_gain_settings();
    test_no_idling();
    if (mismatches == 0 && angle_queue.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
